[rtl/core/ssf_pkg.sv]
// Shared constants, types and the window compare function of the substring finder.
`default_nettype none
package ssf_pkg;

  // Largest pattern the window can hold.
  localparam int MAX_PATTERN = 16;
  // Bytes that the two pattern registers can supply.
  localparam int REG_BYTES   = 16;
  localparam int PAT_LIMIT   = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SEEN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FLD_W  = 5;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;
  localparam int POS_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PAT_LO = 2'd0;
  localparam logic [1:0] REG_PAT_HI = 2'd1;
  localparam logic [1:0] REG_PAT_LEN = 2'd2;

  typedef logic [7:0] byte_t;
  typedef logic [MAX_PATTERN-1:0][7:0] pat_t;

  // Pattern as seen by the compare cells.
  typedef struct packed {
    pat_t             pat;
    logic [LEN_W-1:0] len;
  } cfg_t;

  // A window byte at position pos (0 is the newest) must equal pattern byte
  // len-1-pos; positions at or beyond the pattern length always pass.
  function automatic logic win_ok(input pat_t pat, input logic [LEN_W-1:0] len,
                                  input logic [LEN_W-1:0] pos, input byte_t b);
    logic [LEN_W-1:0] idx;
    logic             res;
    idx = len - pos - LEN_W'(1);
    if (pos < len) begin
      res = (pat[idx[IDX_W-1:0]] == b);
    end else begin
      res = 1'b1;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/core/stream_substring_finder.sv]
// Top level of the stream substring finder: cell chain, stream counters and result register.
//
// Usage:
//   Bytes enter on the in_ channel (in_data_byte, in_end_of_stream marks the
//   last byte of a stream). A word is taken at a clock edge with in_valid high
//   and in_stall low. The pattern (1 to 16 bytes) and its length are written
//   through the cfg_ APB-style port at byte addresses 0, 8 and 16 while the
//   block is idle.
//   Each byte is compared in the same cycle against every alignment held in a
//   chain of byte cells, so one byte is taken every cycle unless in_stall is
//   high. A result word (out_found, out_match_start) appears on the out_
//   channel in the cycle after the byte that completes the first match, or
//   after the end-of-stream byte when the pattern never occurred. At most one
//   result word per stream. Throughput is one byte per cycle while in_stall
//   is low, as the cell compare is combinational. If the result register is
//   full and out_stall is high, in_stall rises and holds off input until the
//   word is taken. Reset (rst_n low, synchronous) clears the stream counters,
//   the result valid flag and the pattern registers (length 1). The
//   end-of-stream byte also clears the stream counters for the next stream.
`default_nettype none
module stream_substring_finder (
  input  wire                        clk,
  input  wire                        rst_n,
  // Input byte channel.
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [7:0]                  in_data_byte,
  input  wire                        in_end_of_stream,
  // Result channel.
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic                       out_found,
  output logic [31:0]                out_match_start,
  // Configuration port.
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire [ssf_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire [ssf_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ssf_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ssf_pkg::*;

  cfg_t                   cfg;
  byte_t                  chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok_vec;
  logic                   in_acc;
  logic                   hit;
  logic                   emit;
  logic [LEN_W-1:0]       back;
  logic [POS_W-1:0]       start;

  logic [POS_W-1:0]  pos_r,      pos_nxt;
  logic [SEEN_W-1:0] seen_r,     seen_nxt;
  logic              finished_r, finished_nxt;
  logic              ovalid_r,   ovalid_nxt;
  logic              found_r,    found_nxt;
  logic [POS_W-1:0]  mstart_r,   mstart_nxt;

  // Configuration registers.
  ssf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Handshake: input waits only while a result word is held up.
  assign in_stall = ovalid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // The newest byte is window position zero and enters the chain.
  assign chain[0]  = in_data_byte;
  assign ok_vec[0] = win_ok(cfg.pat, cfg.len, LEN_W'(0), in_data_byte);

  // Chain of cells, cell j holding the byte j+1 places back.
  for (genvar j = 0; j < MAX_PATTERN - 1; j++) begin : g_cell
    if (j == MAX_PATTERN - 2) begin : g_last
      byte_t tail;
      ssf_cell u_cell (
        .clk      (clk),
        .shift_en (in_acc),
        .byte_in  (chain[j]),
        .cfg      (cfg),
        .pos      (LEN_W'(j + 1)),
        .byte_out (tail),
        .ok       (ok_vec[j+1])
      );
      assign chain[j+1] = tail;
    end else begin : g_mid
      ssf_cell u_cell (
        .clk      (clk),
        .shift_en (in_acc),
        .byte_in  (chain[j]),
        .cfg      (cfg),
        .pos      (LEN_W'(j + 1)),
        .byte_out (chain[j+1]),
        .ok       (ok_vec[j+1])
      );
    end
  end

  // Match decision: enough bytes seen and every aligned cell agrees.
  assign back  = cfg.len - LEN_W'(1);
  assign hit   = ~finished_r & (LEN_W'(seen_r) >= back) & (&ok_vec);
  assign emit  = hit | (~finished_r & in_end_of_stream);
  assign start = (pos_r >= POS_W'(back)) ? (pos_r - POS_W'(back)) : '0;

  // Stream counters and result register next state.
  always_comb begin
    pos_nxt      = pos_r;
    seen_nxt     = seen_r;
    finished_nxt = finished_r;
    ovalid_nxt   = ovalid_r & out_stall;
    found_nxt    = found_r;
    mstart_nxt   = mstart_r;
    if (in_acc) begin
      if (emit) begin
        ovalid_nxt = 1'b1;
        found_nxt  = hit;
        mstart_nxt = hit ? start : '0;
      end
      if (in_end_of_stream) begin
        pos_nxt      = '0;
        seen_nxt     = '0;
        finished_nxt = 1'b0;
      end else begin
        if (seen_r != SEEN_W'(MAX_PATTERN - 1)) begin
          seen_nxt = seen_r + SEEN_W'(1);
        end
        if (pos_r != '1) begin
          pos_nxt = pos_r + POS_W'(1);
        end
        finished_nxt = finished_r | hit;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      seen_r     <= '0;
      finished_r <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      seen_r     <= seen_nxt;
      finished_r <= finished_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    mstart_r <= mstart_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_found       = found_r;
  assign out_match_start = mstart_r;

`ifndef SYNTHESIS
  // A held result word must block input.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_stall |-> in_stall)
    else $error("input taken while result word is held");

  // End of stream clears the stream state.
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_stream |=> pos_r == '0 && seen_r == '0 && !finished_r)
    else $error("stream state not cleared after end of stream");

  // A not-found report carries position zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !found_r |-> mstart_r == '0)
    else $error("not-found word with nonzero position");

  // A finished stream yields no further match.
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !hit)
    else $error("second match in one stream");
`endif

endmodule
`default_nettype wire

[rtl/core/ssf_cell.sv]
// One window cell: holds a past byte, passes it on and compares it to its pattern byte.
`default_nettype none
module ssf_cell (
  input  wire                     clk,
  input  wire                     shift_en,
  input  wire ssf_pkg::byte_t     byte_in,
  input  wire ssf_pkg::cfg_t      cfg,
  input  wire [ssf_pkg::LEN_W-1:0] pos,
  output ssf_pkg::byte_t          byte_out,
  output logic                    ok
);
  import ssf_pkg::*;

  byte_t byte_r;

  // Take the neighbor's byte on every accepted word.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // Compare the held byte against the pattern byte aligned to this position.
  assign ok = win_ok(cfg.pat, cfg.len, pos, byte_r);

endmodule
`default_nettype wire

[rtl/core/ssf_cfg.sv]
// Configuration registers of the substring finder behind an APB-style port.
`default_nettype none
module ssf_cfg (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [ssf_pkg::ADDR_W-1:0] paddr,
  input  wire [ssf_pkg::DATA_W-1:0] pwdata,
  output logic [ssf_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output ssf_pkg::cfg_t             cfg
);
  import ssf_pkg::*;

  logic [DATA_W-1:0] pat_lo_r;
  logic [DATA_W-1:0] pat_hi_r;
  logic [FLD_W-1:0]  len_r;
  logic [1:0]        reg_idx;
  logic              wr_en;
  logic [127:0]      pat_all;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      len_r    <= FLD_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAT_LO:  pat_lo_r <= pwdata;
        REG_PAT_HI:  pat_hi_r <= pwdata;
        REG_PAT_LEN: len_r    <= pwdata[FLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_PAT_LO:  prdata = pat_lo_r;
      REG_PAT_HI:  prdata = pat_hi_r;
      REG_PAT_LEN: prdata = DATA_W'(len_r);
      default:     prdata = '0;
    endcase
  end

  // Pattern bytes as an array; bytes beyond the registers read as zero.
  assign pat_all = {pat_hi_r, pat_lo_r};
  always_comb begin
    cfg.pat = '0;
    for (int i = 0; i < PAT_LIMIT; i++) begin
      cfg.pat[i] = pat_all[8*i +: 8];
    end
  end

  // Effective length: zero counts as one, oversize is clamped to the window.
  always_comb begin
    if (len_r == '0) begin
      cfg.len = LEN_W'(1);
    end else if (32'(len_r) > 32'(MAX_PATTERN)) begin
      cfg.len = LEN_W'(MAX_PATTERN);
    end else begin
      cfg.len = LEN_W'(len_r);
    end
  end

endmodule
`default_nettype wire
